[rtl/mi3_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and width helpers for the 3x3 matrix inverse.
// No dependencies.
package mi3_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int THR_WIDTH      = 16;
  localparam int LANES          = 9;

  typedef struct packed {
    logic             singular;
    logic [LANES-1:0] neg;
  } mi3_side_t;

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int num_w(input int w, input int f);
    return max_i(2 * w + 2 * f + 1, 3 * w + 1) + 1;
  endfunction

  function automatic int rem_w(input int w, input int f);
    return max_i(num_w(w, f), 4 * w + 2);
  endfunction

  function automatic int den_w(input int w);
    return 3 * w + 2;
  endfunction

endpackage

[rtl/mi3_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one 3x3 matrix per beat, row-major elements.
// Depends on mi3_pkg.
interface mi3_in_if #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] in_r0c0;
  logic signed [ELEM_WIDTH-1:0] in_r0c1;
  logic signed [ELEM_WIDTH-1:0] in_r0c2;
  logic signed [ELEM_WIDTH-1:0] in_r1c0;
  logic signed [ELEM_WIDTH-1:0] in_r1c1;
  logic signed [ELEM_WIDTH-1:0] in_r1c2;
  logic signed [ELEM_WIDTH-1:0] in_r2c0;
  logic signed [ELEM_WIDTH-1:0] in_r2c1;
  logic signed [ELEM_WIDTH-1:0] in_r2c2;

  modport source (
    output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    input  ready
  );
  modport sink (
    input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    output ready
  );
endinterface

[rtl/mi3_out_if.sv]
`timescale 1ns / 1ps
// Output channel: inverse matrix plus singular and saturated flags per beat.
// Depends on mi3_pkg.
interface mi3_out_if #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] out_r0c0;
  logic signed [ELEM_WIDTH-1:0] out_r0c1;
  logic signed [ELEM_WIDTH-1:0] out_r0c2;
  logic signed [ELEM_WIDTH-1:0] out_r1c0;
  logic signed [ELEM_WIDTH-1:0] out_r1c1;
  logic signed [ELEM_WIDTH-1:0] out_r1c2;
  logic signed [ELEM_WIDTH-1:0] out_r2c0;
  logic signed [ELEM_WIDTH-1:0] out_r2c1;
  logic signed [ELEM_WIDTH-1:0] out_r2c2;
  logic                         singular;
  logic                         saturated;

  modport source (
    output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, singular, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, singular, saturated,
    output ready
  );
endinterface

[rtl/mi3_div.sv]
`timescale 1ns / 1ps
// Nine-lane pipelined restoring divider, one quotient bit per stage,
// with a leading overflow stage. Depends on mi3_pkg.
module mi3_div #(
  parameter int  ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int  FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF,
  localparam int RW         = mi3_pkg::rem_w(ELEM_WIDTH, FRAC_BITS),
  localparam int DEN        = mi3_pkg::den_w(ELEM_WIDTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RW-1:0]           num_i [mi3_pkg::LANES],
  input  logic [DEN-1:0]          den_i,
  input  mi3_pkg::mi3_side_t      side_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ELEM_WIDTH-1:0]   quo_o [mi3_pkg::LANES],
  output logic [mi3_pkg::LANES-1:0] ovf_o,
  output mi3_pkg::mi3_side_t      side_o
);

  localparam int W   = ELEM_WIDTH;
  localparam int STG = W + 1;
  localparam int NL  = mi3_pkg::LANES;

  logic [STG-1:0]        vld_q;
  logic [STG:0]          rdy;
  logic [RW-1:0]         rem_q  [STG][NL];
  logic [W-1:0]          quo_q  [STG][NL];
  logic [NL-1:0]         ovf_q  [STG];
  logic [DEN-1:0]        den_q  [STG];
  mi3_pkg::mi3_side_t    side_q [STG];

  assign rdy[STG] = out_ready_i;

  for (genvar s = 0; s < STG; s++) begin : g_stg
    logic               vin;
    logic [RW-1:0]      rin [NL];
    logic [W-1:0]       qin [NL];
    logic [NL-1:0]      oin;
    logic [DEN-1:0]     din;
    mi3_pkg::mi3_side_t sin;
    logic [RW-1:0]      rnx [NL];
    logic [W-1:0]       qnx [NL];
    logic [NL-1:0]      onx;
    logic [RW-1:0]      dsh;

    assign rdy[s] = !vld_q[s] || rdy[s+1];

    if (s == 0) begin : g_head
      assign vin = in_valid_i;
      assign rin = num_i;
      assign din = den_i;
      assign sin = side_i;
      assign oin = '0;
      for (genvar l = 0; l < NL; l++) begin : g_q0
        assign qin[l] = '0;
      end
      always_comb begin
        dsh = RW'(din) << W;
        for (int l = 0; l < NL; l++) begin
          onx[l] = oin[l] || (rin[l] >= dsh);
          rnx[l] = rin[l];
          qnx[l] = qin[l];
        end
      end
    end else begin : g_body
      assign vin = vld_q[s-1];
      assign rin = rem_q[s-1];
      assign qin = quo_q[s-1];
      assign oin = ovf_q[s-1];
      assign din = den_q[s-1];
      assign sin = side_q[s-1];
      always_comb begin
        dsh = RW'(din) << (W - s);
        onx = oin;
        for (int l = 0; l < NL; l++) begin
          qnx[l] = qin[l];
          if (rin[l] >= dsh) begin
            rnx[l]        = rin[l] - dsh;
            qnx[l][W - s] = 1'b1;
          end else begin
            rnx[l] = rin[l];
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vin) begin
        rem_q[s]  <= rnx;
        quo_q[s]  <= qnx;
        ovf_q[s]  <= onx;
        den_q[s]  <= din;
        side_q[s] <= sin;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[STG-1];
  assign quo_o       = quo_q[STG-1];
  assign ovf_o       = ovf_q[STG-1];
  assign side_o      = side_q[STG-1];

endmodule

[rtl/matrix_inverse_3x3.sv]
`timescale 1ns / 1ps
// 3x3 inverse by adjugate over determinant, signed fixed point.
// Pipeline: six arithmetic stages, ELEM_WIDTH + 1 divider stages (an overflow stage,
// then one quotient bit per stage), one output stage.
// Throughput: one matrix per cycle while the output is not stalled; every stage holds its beat under back-pressure.
// Reset clears all valid bits and sets the singular threshold to zero.
// Depends on mi3_pkg, mi3_in_if, mi3_out_if and mi3_div.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mi3_pkg::THR_WIDTH-1:0]  cfg_wdata_i,
  mi3_in_if.sink                         in_ch,
  mi3_out_if.source                      out_ch
);

  localparam int W    = ELEM_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NL   = mi3_pkg::LANES;
  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int XW   = 2 * W + 1;
  localparam int DW   = 3 * W + 2;
  localparam int CM   = 2 * W;
  localparam int DM   = 3 * W + 1;
  localparam int RW   = mi3_pkg::rem_w(W, F);
  localparam int DEN  = mi3_pkg::den_w(W);
  localparam int CMPW = mi3_pkg::max_i(DW, mi3_pkg::THR_WIDTH + 2 * F + 1);
  localparam bit ONE_SAT = (F >= W - 1);
  localparam logic [W-1:0] POS_LIM = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] NEG_LIM = {1'b1, {(W - 1){1'b0}}};
  localparam logic [W-1:0] ONE_VAL = ONE_SAT ? POS_LIM : (W'(1) << F);

  localparam int IP [NL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IQ [NL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IS [NL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int IU [NL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic [mi3_pkg::THR_WIDTH-1:0] thr_q;
  logic signed [W-1:0] a [NL];

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_o, div_rdy;
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, ov_q;

  logic signed [PW-1:0] pa_q [NL], pb_q [NL], pa_d [NL], pb_d [NL];
  logic signed [W-1:0]  ra_q [3], rb_q [3];
  logic signed [CW-1:0] cof_b_q [NL], cof_c_q [NL], cof_d_q [NL], cof_b_d [NL];
  logic signed [XW-1:0] ph_q [3], pl_q [3], ph_d [3], pl_d [3];
  logic signed [DW-1:0] det_q, det_d;
  logic [CM-1:0]        cmag_q [NL], cmag_d [NL];
  logic [NL-1:0]        cneg_q;
  logic [DM-1:0]        dmag_q, dmag_d;
  logic                 dneg_q, sing_e_q, sing_e_d;
  logic signed [CMPW-1:0] dext, tpos, tneg;
  logic [RW-1:0]        num_q [NL], num_d [NL];
  logic [DEN-1:0]       den_q;
  mi3_pkg::mi3_side_t   side_f_q, side_o;
  logic                 div_vld;
  logic [W-1:0]         quo [NL];
  logic [NL-1:0]        ovf;
  logic [W-1:0]         res_q [NL], res_d [NL];
  logic                 sing_o_q, sat_o_q, sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign a[0] = in_ch.in_r0c0;
  assign a[1] = in_ch.in_r0c1;
  assign a[2] = in_ch.in_r0c2;
  assign a[3] = in_ch.in_r1c0;
  assign a[4] = in_ch.in_r1c1;
  assign a[5] = in_ch.in_r1c2;
  assign a[6] = in_ch.in_r2c0;
  assign a[7] = in_ch.in_r2c1;
  assign a[8] = in_ch.in_r2c2;

  assign rdy_o = !ov_q || out_ch.ready;
  assign rdy_f = !vf_q || div_rdy;
  assign rdy_e = !ve_q || rdy_f;
  assign rdy_d = !vd_q || rdy_e;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ch.ready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_ch.valid;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_e) ve_q <= vd_q;
      if (rdy_f) vf_q <= ve_q;
      if (rdy_o) ov_q <= div_vld;
    end
  end

  // Cofactor products, cofactors, determinant partial products, determinant.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      pa_d[i]    = PW'(a[IP[i]]) * PW'(a[IQ[i]]);
      pb_d[i]    = PW'(a[IS[i]]) * PW'(a[IU[i]]);
      cof_b_d[i] = CW'(pa_q[i]) - CW'(pb_q[i]);
    end
    for (int j = 0; j < 3; j++) begin
      pl_d[j] = XW'(rb_q[j]) * XW'($signed({1'b0, cof_b_q[3 * j][W-1:0]}));
      ph_d[j] = XW'(rb_q[j]) * XW'($signed(cof_b_q[3 * j][CW-1:W]));
    end
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DW'(ph_q[j]) <<< W) + DW'(pl_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_ch.valid) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      ra_q <= a[0:2];
    end
    if (rdy_b && va_q) begin
      cof_b_q <= cof_b_d;
      rb_q    <= ra_q;
    end
    if (rdy_c && vb_q) begin
      ph_q    <= ph_d;
      pl_q    <= pl_d;
      cof_c_q <= cof_b_q;
    end
    if (rdy_d && vc_q) begin
      det_q   <= det_d;
      cof_d_q <= cof_c_q;
    end
  end

  // Magnitudes and the singular test.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      cmag_d[i] = cof_d_q[i][CW-1] ? CM'(-cof_d_q[i]) : CM'(cof_d_q[i]);
    end
    dmag_d   = det_q[DW-1] ? DM'(-det_q) : DM'(det_q);
    dext     = CMPW'(det_q);
    tpos     = $signed(CMPW'(thr_q) << (2 * F));
    tneg     = -tpos;
    sing_e_d = (dext <= tpos) && (dext >= tneg);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && vd_q) begin
      cmag_q   <= cmag_d;
      for (int i = 0; i < NL; i++) cneg_q[i] <= cof_d_q[i][CW-1];
      dmag_q   <= dmag_d;
      dneg_q   <= det_q[DW-1];
      sing_e_q <= sing_e_d;
    end
  end

  // Rounding numerator and doubled divisor.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      num_d[i] = (RW'(cmag_q[i]) << (2 * F + 1)) + RW'(dmag_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f && ve_q) begin
      num_q             <= num_d;
      den_q             <= DEN'(dmag_q) << 1;
      side_f_q.singular <= sing_e_q;
      side_f_q.neg      <= cneg_q ^ {NL{dneg_q}};
    end
  end

  mi3_div #(
    .ELEM_WIDTH (W),
    .FRAC_BITS  (F)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vf_q),
    .in_ready_o  (div_rdy),
    .num_i       (num_q),
    .den_i       (den_q),
    .side_i      (side_f_q),
    .out_valid_o (div_vld),
    .out_ready_i (rdy_o),
    .quo_o       (quo),
    .ovf_o       (ovf),
    .side_o      (side_o)
  );

  // Saturate, restore sign, or substitute identity.
  always_comb begin
    logic [W-1:0] lim;
    logic [W-1:0] mag;
    logic         clip;
    sat_d = 1'b0;
    for (int i = 0; i < NL; i++) begin
      lim  = side_o.neg[i] ? NEG_LIM : POS_LIM;
      clip = ovf[i] || (quo[i] > lim);
      mag  = clip ? lim : quo[i];
      if (side_o.singular) begin
        res_d[i] = (i % 4 == 0) ? ONE_VAL : '0;
      end else begin
        res_d[i] = side_o.neg[i] ? W'(-mag) : mag;
        sat_d    = sat_d | clip;
      end
    end
    if (side_o.singular) begin
      sat_d = ONE_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && div_vld) begin
      res_q    <= res_d;
      sing_o_q <= side_o.singular;
      sat_o_q  <= sat_d;
    end
  end

  assign out_ch.valid     = ov_q;
  assign out_ch.out_r0c0  = res_q[0];
  assign out_ch.out_r0c1  = res_q[1];
  assign out_ch.out_r0c2  = res_q[2];
  assign out_ch.out_r1c0  = res_q[3];
  assign out_ch.out_r1c1  = res_q[4];
  assign out_ch.out_r1c2  = res_q[5];
  assign out_ch.out_r2c0  = res_q[6];
  assign out_ch.out_r2c1  = res_q[7];
  assign out_ch.out_r2c2  = res_q[8];
  assign out_ch.singular  = sing_o_q;
  assign out_ch.saturated = sat_o_q;

  a_zero_det_singular : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ve_q && dmag_q == '0) |-> sing_e_q
  ) else $error("zero determinant not flagged singular");

  a_singular_identity : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ov_q && sing_o_q) |-> (res_q[1] == '0 && res_q[2] == '0 && res_q[3] == '0 &&
                            res_q[5] == '0 && res_q[6] == '0 && res_q[7] == '0 &&
                            res_q[0] == ONE_VAL && sat_o_q == ONE_SAT)
  ) else $error("singular beat is not the identity");

  a_front_hold : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (vd_q && !rdy_e) |=> (vd_q && $stable(det_q))
  ) else $error("determinant stage lost its beat under stall");

endmodule

[sim/matrix_inverse_3x3_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for matrix_inverse_3x3: directed and random matrices, threshold phases,
// random stalls on both channels, results checked against an exact wide-integer inverse.
// Depends on mi3_pkg, mi3_in_if, mi3_out_if and the matrix_inverse_3x3 RTL.
module matrix_inverse_3x3_tb;

  localparam int W = 32;
  localparam int TW = mi3_pkg::THR_WIDTH;
  localparam int SETTLE = 60;

  typedef logic [8:0][W-1:0] mat_t;
  typedef struct {
    bit                    is_cfg;
    logic [TW-1:0]         thr;
    mat_t                  m;
  } job_t;
  typedef struct {
    mat_t el;
    logic singular;
    logic saturated;
  } inv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TW-1:0] cfg_wdata_i = '0;

  mi3_in_if  #(.ELEM_WIDTH(W)) in_ch ();
  mi3_out_if #(.ELEM_WIDTH(W)) out_ch ();

  matrix_inverse_3x3 dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #6 clk_i = ~clk_i;

  job_t pending_q[$];
  inv_t inverse_q[$];
  logic [TW-1:0] thr_model = '0;
  int errors = 0, n_sent = 0, n_got = 0, n_sing = 0, n_sat = 0, n_cfg = 0;

  function automatic logic [127:0] mag(input logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic inv_t invert(input mat_t m, input logic [TW-1:0] thr);
    logic signed [127:0] a[9];
    logic signed [127:0] c[9];
    logic signed [127:0] det;
    logic [127:0] dm, cm, q, lim;
    logic neg;
    inv_t r;
    for (int i = 0; i < 9; i++) a[i] = {{96{m[i][W-1]}}, m[i]};
    c[0] = a[4] * a[8] - a[5] * a[7];
    c[1] = a[2] * a[7] - a[1] * a[8];
    c[2] = a[1] * a[5] - a[2] * a[4];
    c[3] = a[5] * a[6] - a[3] * a[8];
    c[4] = a[0] * a[8] - a[2] * a[6];
    c[5] = a[2] * a[3] - a[0] * a[5];
    c[6] = a[3] * a[7] - a[4] * a[6];
    c[7] = a[1] * a[6] - a[0] * a[7];
    c[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
    dm = mag(det);
    r.saturated = 1'b0;
    if (dm <= ({112'd0, thr} << 32)) begin
      r.singular = 1'b1;
      for (int i = 0; i < 9; i++) r.el[i] = (i % 4 == 0) ? W'(1 << 16) : '0;
      return r;
    end
    r.singular = 1'b0;
    for (int i = 0; i < 9; i++) begin
      cm = mag(c[i]);
      neg = (c[i] < 0) != (det < 0);
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      q = ((cm << 33) + dm) / (dm << 1);
      if (q > lim) begin
        q = lim;
        r.saturated = 1'b1;
      end
      r.el[i] = neg ? W'(-q) : W'(q);
    end
    return r;
  endfunction

  // driver
  logic vin;
  mat_t cur;
  int gap, settle;
  assign in_ch.valid = vin;
  assign {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1,
          in_ch.in_r1c0, in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} = cur;

  function automatic int draw_gap(input int count);
    return ((count / 150) % 3 == 1) ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin <= 1'b0;
      cur <= '0;
      gap <= 0;
      settle <= 0;
      cfg_we_i <= 1'b0;
      cfg_wdata_i <= '0;
    end else begin
      if (vin && in_ch.ready) begin
        inverse_q.push_back(invert(cur, thr_model));
        n_sent++;
      end
      settle <= (inverse_q.size() != 0 || vin) ? 0 : (settle < 1000 ? settle + 1 : settle);
      if (vin && !in_ch.ready) begin
        cfg_we_i <= 1'b0;
      end else if (gap > 0) begin
        gap <= gap - 1;
        vin <= 1'b0;
        cfg_we_i <= 1'b0;
      end else if (pending_q.size() != 0 && pending_q[0].is_cfg) begin
        vin <= 1'b0;
        if (!vin && settle >= SETTLE && !cfg_we_i) begin
          cfg_we_i <= 1'b1;
          cfg_wdata_i <= pending_q[0].thr;
          thr_model = pending_q[0].thr;
          n_cfg++;
          void'(pending_q.pop_front());
        end else begin
          cfg_we_i <= 1'b0;
        end
      end else if (pending_q.size() != 0) begin
        cfg_we_i <= 1'b0;
        vin <= 1'b1;
        cur <= pending_q[0].m;
        void'(pending_q.pop_front());
        gap <= draw_gap(n_sent);
      end else begin
        cfg_we_i <= 1'b0;
        vin <= 1'b0;
      end
    end
  end

  // monitor
  logic rdy;
  int stall;
  assign out_ch.ready = rdy;

  task automatic check_field(input string name, input logic [W-1:0] exp, input logic [W-1:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, got %h", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    inv_t e;
    int st;
    mat_t got;
    if (!rst_ni) begin
      rdy <= 1'b0;
      stall <= 0;
    end else if (out_ch.valid && rdy) begin
      got = {out_ch.out_r2c2, out_ch.out_r2c1, out_ch.out_r2c0, out_ch.out_r1c2,
             out_ch.out_r1c1, out_ch.out_r1c0, out_ch.out_r0c2, out_ch.out_r0c1,
             out_ch.out_r0c0};
      n_got++;
      if (inverse_q.size() == 0) begin
        $error("result beat with no matrix outstanding");
        errors++;
      end else begin
        e = inverse_q.pop_front();
        for (int i = 0; i < 9; i++)
          check_field($sformatf("out_r%0dc%0d", i / 3, i % 3), e.el[i], got[i]);
        check_field("singular", W'(e.singular), W'(out_ch.singular));
        check_field("saturated", W'(e.saturated), W'(out_ch.saturated));
        n_sing += e.singular;
        n_sat += e.saturated;
      end
      st = draw_gap(n_got + 75);
      stall <= st;
      rdy <= (st == 0);
    end else if (stall > 0) begin
      stall <= stall - 1;
      rdy <= (stall == 1);
    end else begin
      rdy <= 1'b1;
    end
  end

  task automatic add_mat(input mat_t m);
    job_t j;
    j.is_cfg = 1'b0;
    j.thr = '0;
    j.m = m;
    pending_q.push_back(j);
  endtask

  task automatic add_cfg(input logic [TW-1:0] t);
    job_t j;
    j.is_cfg = 1'b1;
    j.thr = t;
    j.m = '0;
    pending_q.push_back(j);
  endtask

  function automatic mat_t diag(input logic [W-1:0] x, input logic [W-1:0] y,
                                input logic [W-1:0] z);
    mat_t m = '0;
    m[0] = x;
    m[4] = y;
    m[8] = z;
    return m;
  endfunction

  function automatic logic [W-1:0] near(input int span);
    return W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic mat_t rand_mat();
    mat_t m;
    int k = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) m[i] = near(1 << 18);
    if (k < 2) begin
      for (int i = 0; i < 9; i++) m[i] = $urandom;
    end else if (k < 4) begin
      for (int i = 0; i < 3; i++) m[6 + i] = m[i] + m[3 + i] + near(4);
    end else if (k == 4) begin
      m = diag(near(64), near(1 << 16), near(1 << 20));
      m[$urandom_range(1, 3)] = near(16);
    end else if (k == 5) begin
      for (int i = 0; i < 9; i++) m[i] = near(1 << 9);
    end
    return m;
  endfunction

  localparam logic [W-1:0] ONE = W'(1 << 16);
  localparam logic [W-1:0] MAXV = 32'h7fff_ffff;
  localparam logic [W-1:0] MINV = 32'h8000_0000;

  initial begin
    mat_t m;
    logic [TW-1:0] phase_thr[5];
    phase_thr = '{16'd0, 16'hffff, 16'd0, 16'd1, 16'd0};
    phase_thr[2] = TW'($urandom_range(2, 65534));
    add_cfg(16'd0);
    add_mat('0);
    add_mat(diag(ONE, ONE, ONE));
    add_mat(diag(MAXV, MAXV, MAXV));
    add_mat(diag(MINV, MINV, MINV));
    add_mat({9{MAXV}});
    add_mat({9{MINV}});
    add_mat(diag(32'd1, ONE, ONE));
    add_mat(diag(-32'sd1, ONE, ONE));
    add_mat(diag(32'd1, 32'd1, 32'd1));
    add_mat(diag(MAXV, MINV, 32'd1));
    m = {MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV};
    add_mat(m);
    add_mat(diag(ONE * 2, -ONE * 4, ONE / 2));
    for (int p = 0; p < 5; p++) begin
      add_cfg(phase_thr[p]);
      if (p == 1) begin
        add_mat(diag(ONE, ONE, 32'd65535));
        add_mat(diag(ONE, ONE, 32'd65536));
        add_mat(diag(ONE, ONE, -32'sd65535));
        add_mat(diag(ONE, ONE, -32'sd65536));
        add_mat(diag(ONE, ONE, ONE));
      end
      for (int i = 0; i < 250; i++) add_mat(rand_mat());
    end
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!(pending_q.size() == 0 && !vin && inverse_q.size() == 0)) @(posedge clk_i);
    repeat (W + 8 + 20) @(posedge clk_i);
    $display("covered %0d matrices, %0d singular, %0d saturated, %0d threshold writes",
             n_sent, n_sing, n_sat, n_cfg);
    if (errors == 0 && inverse_q.size() == 0)
      $display("PASS matrix_inverse_3x3");
    else
      $display("FAIL matrix_inverse_3x3");
    $finish;
  end

  initial begin
    #3ms;
    $display("FAIL matrix_inverse_3x3");
    $finish;
  end

endmodule

[filelist.f]
rtl/mi3_pkg.sv
rtl/mi3_in_if.sv
rtl/mi3_out_if.sv
rtl/mi3_div.sv
rtl/matrix_inverse_3x3.sv
sim/matrix_inverse_3x3_tb.sv
